@@ rtl/dicdf_pkg.sv @@
// Shared widths, function codes and register indexes for the radius sampler.
// No dependencies; every other file in rtl/ imports this package.
package dicdf_pkg;

    // table and bin limits
    localparam int TABLE_DEPTH = 64;
    localparam int MAX_BINS    = 256;

    // field widths
    localparam int DATA_W    = 32;
    localparam int ENTRY_W   = 6;
    localparam int ENTRIES_W = 7;
    localparam int BINC_W    = 9;
    localparam int BINOUT_W  = 8;
    localparam int CFG_IDX_W = 2;

    // bin search: index width, bit-position counter width, edge and midpoint widths
    localparam int BIN_W  = BINC_W;
    localparam int BPOS_W = $clog2(BIN_W);
    localparam int EDGE_W = DATA_W + BIN_W + 1;
    localparam int MID_W  = EDGE_W + 1;

    typedef logic [1:0]           func_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // request codes
    localparam func_t FUNC_LOAD     = 2'd0;
    localparam func_t FUNC_DRAW     = 2'd1;
    localparam func_t FUNC_CLASSIFY = 2'd2;

    // register indexes
    localparam cfg_idx_t CFG_ENTRIES   = 2'd0;
    localparam cfg_idx_t CFG_BIN_COUNT = 2'd1;
    localparam cfg_idx_t CFG_ORIGIN    = 2'd2;
    localparam cfg_idx_t CFG_WIDTH     = 2'd3;

endpackage

@@ rtl/discrete_inverse_cdf_radius_sampler_unit.sv @@
// Classify with binning off: done strobes in the cycle after accept; a load gives no result.
// Draw: read state then compare state per table entry scanned (linear scan, one read port).
// Binning adds setup, a 9-bit edge search (top bit always out of range, each lower bit a range
// check, then an edge compare if in range; skipped below the origin), finish, midpoint (draw).
// Busy covers the item; a command can be accepted while done is high; loads go back to back.
// Results are one-cycle strobes (done); the receiver cannot stall. Reset: control and config.
module discrete_inverse_cdf_radius_sampler_unit
    import dicdf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           func,
    input  logic [ENTRY_W-1:0]   entry_index,
    input  logic [DATA_W-1:0]    entry_cumulative,
    input  logic [DATA_W-1:0]    entry_radius,
    input  logic [DATA_W-1:0]    uniform_draw,
    input  logic [DATA_W-1:0]    query_radius,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // result strobe
    output logic                 done,
    output logic [DATA_W-1:0]    radius_out,
    output logic [ENTRY_W-1:0]   chosen_entry,
    output logic [BINOUT_W-1:0]  bin_number,
    output logic                 binned
);

    localparam int TAB_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_BIN0,
        S_MUL,
        S_CMPB,
        S_FIN,
        S_MID
    } state_t;

    // configuration registers
    logic [ENTRIES_W-1:0] entries_reg;
    logic [BINC_W-1:0]    bin_count_reg;
    logic [DATA_W-1:0]    bin_origin_reg;
    logic [DATA_W-1:0]    bin_width_reg;

    // sequencer state
    state_t               state_reg,     state_next;
    logic                 is_draw_reg,   is_draw_next;
    logic [DATA_W-1:0]    key_reg,       key_next;
    logic [DATA_W-1:0]    val_reg,       val_next;
    logic [ENTRIES_W-1:0] n_reg,         n_next;
    logic [ENTRIES_W-1:0] idx_reg,       idx_next;
    logic [BINC_W-1:0]    bins_reg,      bins_next;
    logic                 below_reg,     below_next;
    logic [BIN_W-1:0]     k_reg,         k_next;
    logic [BPOS_W-1:0]    bpos_reg,      bpos_next;

    // result registers
    logic                 done_reg,      done_next;
    logic [DATA_W-1:0]    radius_reg,    radius_next;
    logic [ENTRY_W-1:0]   chosen_reg,    chosen_next;
    logic [BINOUT_W-1:0]  bin_out_reg,   bin_out_next;
    logic                 binned_reg,    binned_next;

    // table memories and read data
    logic [DATA_W-1:0]    cum_mem [TABLE_DEPTH];
    logic [DATA_W-1:0]    rad_mem [TABLE_DEPTH];
    logic [DATA_W-1:0]    rd_cum_reg;
    logic [DATA_W-1:0]    rd_rad_reg;

    logic                 accept;
    logic                 load_we;
    logic [ENTRIES_W-1:0] n_clamped;
    logic [BINC_W-1:0]    bins_clamped;
    logic [BINC_W-1:0]    bins_m1;
    logic [BIN_W-1:0]     cand;
    logic                 cand_ok;
    logic [BIN_W-1:0]     bin_sel;
    logic [BIN_W-1:0]     edge_idx;
    logic [EDGE_W-1:0]    edge_value;
    logic                 edge_le;
    logic [MID_W-1:0]     mid;
    logic [DATA_W-1:0]    mid_sat;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign load_we   = accept && (func == FUNC_LOAD) && (32'(entry_index) < TABLE_DEPTH);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg    <= ENTRIES_W'(1);
            bin_count_reg  <= '0;
            bin_origin_reg <= '0;
            bin_width_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENTRIES:   entries_reg    <= cfg_data[ENTRIES_W-1:0];
                CFG_BIN_COUNT: bin_count_reg  <= cfg_data[BINC_W-1:0];
                CFG_ORIGIN:    bin_origin_reg <= cfg_data;
                CFG_WIDTH:     bin_width_reg  <= cfg_data;
            endcase
        end
    end

    // table memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            cum_mem[TAB_AW'(entry_index)] <= entry_cumulative;
            rad_mem[TAB_AW'(entry_index)] <= entry_radius;
        end
        rd_cum_reg <= cum_mem[TAB_AW'(idx_reg)];
        rd_rad_reg <= rad_mem[TAB_AW'(idx_reg)];
    end

    // clamped counts taken at accept
    always_comb
    begin
        if (entries_reg == '0)
            n_clamped = ENTRIES_W'(1);
        else if (32'(entries_reg) > TABLE_DEPTH)
            n_clamped = ENTRIES_W'(TABLE_DEPTH);
        else
            n_clamped = entries_reg;
        bins_clamped = (32'(bin_count_reg) > MAX_BINS) ? BINC_W'(MAX_BINS) : bin_count_reg;
    end

    // bin search datapath
    assign bins_m1  = bins_reg - BINC_W'(1);
    assign cand     = k_reg | (BIN_W'(1) << bpos_reg);
    assign cand_ok  = (cand <= bins_m1);
    assign edge_le  = (edge_value <= EDGE_W'(val_reg));
    assign bin_sel  = below_reg ? (is_draw_reg ? bins_m1 : '0) : k_reg;
    assign edge_idx = (state_reg == S_FIN) ? bin_sel : cand;

    // midpoint of [edge, edge + width] is edge + width/2, saturated to 32 bits
    assign mid     = MID_W'(edge_value) + MID_W'(bin_width_reg >> 1);
    assign mid_sat = (|mid[MID_W-1:DATA_W]) ? '1 : mid[DATA_W-1:0];

    dicdf_edge_unit u_edge
    (
        .clk        (clk),
        .origin     (bin_origin_reg),
        .step       (bin_width_reg),
        .index      (edge_idx),
        .edge_value (edge_value)
    );

    // sequencer next-state logic
    always_comb
    begin
        state_next   = state_reg;
        is_draw_next = is_draw_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        bins_next    = bins_reg;
        below_next   = below_reg;
        k_next       = k_reg;
        bpos_next    = bpos_reg;
        done_next    = 1'b0;
        radius_next  = radius_reg;
        chosen_next  = chosen_reg;
        bin_out_next = bin_out_reg;
        binned_next  = binned_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_DRAW:
                        begin
                            is_draw_next = 1'b1;
                            key_next     = uniform_draw;
                            n_next       = n_clamped;
                            idx_next     = '0;
                            bins_next    = bins_clamped;
                            state_next   = S_RD;
                        end
                        FUNC_CLASSIFY:
                        begin
                            is_draw_next = 1'b0;
                            val_next     = query_radius;
                            bins_next    = bins_clamped;
                            if (bins_clamped == '0)
                            begin
                                done_next    = 1'b1;
                                radius_next  = '0;
                                chosen_next  = '0;
                                bin_out_next = '0;
                                binned_next  = 1'b0;
                            end
                            else
                                state_next = S_BIN0;
                        end
                        default:
                        begin
                            // load is handled by the memory write; unused code is dropped
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // first entry at or above the draw, else the last entry in use
                if ((rd_cum_reg >= key_reg) || (idx_reg == n_reg - ENTRIES_W'(1)))
                begin
                    val_next = rd_rad_reg;
                    if (bins_reg == '0)
                    begin
                        done_next    = 1'b1;
                        radius_next  = rd_rad_reg;
                        chosen_next  = idx_reg[ENTRY_W-1:0];
                        bin_out_next = '0;
                        binned_next  = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                        state_next = S_BIN0;
                end
                else
                begin
                    idx_next   = idx_reg + ENTRIES_W'(1);
                    state_next = S_RD;
                end
            end
            S_BIN0:
            begin
                // edge 0 is the origin; below it the search is skipped
                below_next = (bin_origin_reg > val_reg);
                k_next     = '0;
                bpos_next  = BPOS_W'(BIN_W - 1);
                state_next = (bin_origin_reg > val_reg) ? S_FIN : S_MUL;
            end
            S_MUL:
            begin
                if (cand_ok)
                    state_next = S_CMPB;
                else if (bpos_reg == '0)
                    state_next = S_FIN;
                else
                    bpos_next = bpos_reg - BPOS_W'(1);
            end
            S_CMPB:
            begin
                if (edge_le)
                    k_next = cand;
                if (bpos_reg == '0)
                    state_next = S_FIN;
                else
                begin
                    bpos_next  = bpos_reg - BPOS_W'(1);
                    state_next = S_MUL;
                end
            end
            S_FIN:
            begin
                k_next = bin_sel;
                if (!is_draw_reg)
                begin
                    done_next    = 1'b1;
                    radius_next  = '0;
                    chosen_next  = '0;
                    bin_out_next = bin_sel[BINOUT_W-1:0];
                    binned_next  = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                    state_next = S_MID;
            end
            S_MID:
            begin
                done_next    = 1'b1;
                radius_next  = mid_sat;
                chosen_next  = idx_reg[ENTRY_W-1:0];
                bin_out_next = k_reg[BINOUT_W-1:0];
                binned_next  = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_draw_reg <= is_draw_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        bins_reg    <= bins_next;
        below_reg   <= below_next;
        k_reg       <= k_next;
        bpos_reg    <= bpos_next;
        radius_reg  <= radius_next;
        chosen_reg  <= chosen_next;
        bin_out_reg <= bin_out_next;
        binned_reg  <= binned_next;
    end

    assign done         = done_reg;
    assign radius_out   = radius_reg;
    assign chosen_entry = chosen_reg;
    assign bin_number   = bin_out_reg;
    assign binned       = binned_reg;

    // compare always follows its memory read
    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> ($past(state_reg) == S_RD))
        else $error("compare without a preceding table read");

    // scan never runs past the last entry in use
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_CMP) |-> (idx_reg < n_reg))
        else $error("table scan beyond entries in use");

    // an edge compare only happens for an index inside the bin range
    a_cand_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMPB) |-> ($past(state_reg) == S_MUL && cand <= bins_m1))
        else $error("bin search compared an out-of-range edge");

    // a binned result needs binning on
    a_binned_bins: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && binned_reg) |-> (bins_reg != '0))
        else $error("binned result with binning off");

    // classify results carry no radius and no entry
    a_classify_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !is_draw_reg) |-> (radius_reg == '0 && chosen_reg == '0))
        else $error("classify result with nonzero radius or entry");

endmodule

@@ rtl/dicdf_edge_unit.sv @@
// Shared bin edge unit: edge = origin + step * index, exact, registered.
// Depends on dicdf_pkg.
module dicdf_edge_unit
    import dicdf_pkg::*;
(
    input  logic              clk,
    input  logic [DATA_W-1:0] origin,
    input  logic [DATA_W-1:0] step,
    input  logic [BIN_W-1:0]  index,
    output logic [EDGE_W-1:0] edge_value
);

    logic [EDGE_W-1:0] edge_val_reg;
    logic [EDGE_W-1:0] edge_val_next;

    // one 32x9 multiply plus the origin add
    always_comb
    begin
        edge_val_next = EDGE_W'(step) * EDGE_W'(index) + EDGE_W'(origin);
    end

    always_ff @(posedge clk)
    begin
        edge_val_reg <= edge_val_next;
    end

    assign edge_value = edge_val_reg;

endmodule
